FILE: rtl/dsa_pkg.sv
package dsa_pkg;

    localparam int REG_P = 0;
    localparam int REG_Q = 1;
    localparam int REG_G = 2;
    localparam int REG_X = 3;
    localparam int REG_Y = 4;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NONCE  = 2'd1;
    localparam logic [1:0] ST_RANGE  = 2'd2;

    localparam logic CMD_SIGN   = 1'b0;
    localparam logic CMD_VERIFY = 1'b1;

    // shared-unit operations
    typedef enum logic [1:0] {
        OP_MUL = 2'd0,
        OP_MOD = 2'd1
    } t_op;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK,
        S_RED_H,
        S_RED_K,
        S_RED_X,
        S_RED_G,
        S_RED_Y,
        S_INV_DIV,
        S_INV_MUL,
        S_INV_STEP,
        S_INV_END,
        S_EXP_SQ,
        S_EXP_MUL,
        S_EXP_END,
        S_SIGN_R,
        S_SIGN_XR,
        S_SIGN_S,
        S_VER_U1,
        S_VER_U2,
        S_VER_V,
        S_VER_VQ,
        S_OUT
    } t_state;

endpackage

FILE: rtl/dsa_mod_unit.sv
// Shared sequential unit: a*b mod m by shift-and-add (one bit per cycle),
// or a mod m / a div m by restoring division (one quotient bit per cycle).
module dsa_mod_unit #(
    parameter int WORD_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  dsa_pkg::t_op         i_op,
    input  logic [WORD_BITS-1:0] i_a,
    input  logic [WORD_BITS-1:0] i_b,
    input  logic [WORD_BITS-1:0] i_m,
    output logic                 o_done,
    output logic [WORD_BITS-1:0] o_res,
    output logic [WORD_BITS-1:0] o_quo
);
    localparam int CW = $clog2(WORD_BITS + 1);

    logic                 r_busy, n_busy;
    dsa_pkg::t_op         r_op, n_op;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic [WORD_BITS-1:0] r_a, n_a, r_b, n_b, r_m, n_m, r_acc, n_acc, r_quo, n_quo;
    logic                 r_done, n_done;
    logic [WORD_BITS:0]   w_dbl, w_sum, w_rem;
    logic [WORD_BITS-1:0] w_accm;

    always_comb begin
        // multiply: acc = 2*acc + a*bit (MSB first), reduce twice
        w_dbl  = {r_acc, 1'b0};
        w_dbl  = (w_dbl >= {1'b0, r_m}) ? w_dbl - {1'b0, r_m} : w_dbl;
        w_accm = w_dbl[WORD_BITS-1:0];
        w_sum  = {1'b0, w_accm} + (r_b[WORD_BITS-1] ? {1'b0, r_a} : '0);
        w_sum  = (w_sum >= {1'b0, r_m}) ? w_sum - {1'b0, r_m} : w_sum;
        // divide: shift dividend bit into remainder
        w_rem  = {r_acc, r_a[WORD_BITS-1]};
    end

    always_comb begin
        n_busy = r_busy; n_op = r_op; n_cnt = r_cnt; n_a = r_a; n_b = r_b;
        n_m = r_m; n_acc = r_acc; n_quo = r_quo; n_done = 1'b0;
        if (i_start) begin
            n_busy = 1'b1; n_op = i_op; n_a = i_a; n_b = i_b; n_m = i_m;
            n_acc = '0; n_quo = '0; n_cnt = CW'(WORD_BITS);
        end else if (r_busy) begin
            case (r_op)
                dsa_pkg::OP_MUL: begin
                    n_acc = w_sum[WORD_BITS-1:0];
                    n_b   = {r_b[WORD_BITS-2:0], 1'b0};
                end
                default: begin
                    n_a = {r_a[WORD_BITS-2:0], 1'b0};
                    if (w_rem >= {1'b0, r_m}) begin
                        n_acc = WORD_BITS'(w_rem - {1'b0, r_m});
                        n_quo = {r_quo[WORD_BITS-2:0], 1'b1};
                    end else begin
                        n_acc = w_rem[WORD_BITS-1:0];
                        n_quo = {r_quo[WORD_BITS-2:0], 1'b0};
                    end
                end
            endcase
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_op <= n_op; r_a <= n_a; r_b <= n_b; r_m <= n_m;
        r_acc <= n_acc; r_quo <= n_quo;
    end

    assign o_done = r_done;
    assign o_res  = r_acc;
    assign o_quo  = r_quo;
endmodule

FILE: rtl/dsa_sign_verify.sv
// DSA sign / verify engine on one shared bit-serial modular unit.
// Each multiply or reduction holds its state until the shared unit reports done; the time a sign
// or a verify takes is set by the inverse and exponentiation loops on the shared unit.
// One request at a time; the result waits in an output register, so the next request can be
// taken in the cycle after the result is loaded. Reset: synchronous active-low, p=23 q=11 g=4 x=1 y=4.
module dsa_sign_verify #(
    parameter int WORD_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_index,
    input  logic [WORD_BITS-1:0] i_cfg_data,
    // request
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_cmd,
    input  logic [31:0]          i_hash_value,
    input  logic [31:0]          i_nonce,
    input  logic [31:0]          i_sig_r,
    input  logic [31:0]          i_sig_s,
    // result
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [31:0]          o_out_r,
    output logic [31:0]          o_out_s,
    output logic                 o_valid_res,
    output logic [1:0]           o_status
);
    localparam int W = WORD_BITS;

    // configuration registers
    logic [W-1:0] r_p, r_q, r_g, r_x, r_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p <= W'(23); r_q <= W'(11); r_g <= W'(4); r_x <= W'(1); r_y <= W'(4);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                3'(dsa_pkg::REG_P): r_p <= i_cfg_data;
                3'(dsa_pkg::REG_Q): r_q <= i_cfg_data;
                3'(dsa_pkg::REG_G): r_g <= i_cfg_data;
                3'(dsa_pkg::REG_X): r_x <= i_cfg_data;
                3'(dsa_pkg::REG_Y): r_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    dsa_pkg::t_state r_st, n_st;

    // request and working registers
    logic         r_cmd;
    logic [W-1:0] r_h, r_k, r_rin, r_sin;
    logic [W-1:0] r_xm, r_gm, r_ym;
    // inverse: r0, r1, t0, t1, quotient
    logic [W-1:0] r_r0, r_r1, r_t0, r_t1, r_qt, r_inv;
    // exponent: base, exponent, accumulator, first result, which exponentiation
    logic [W-1:0] r_eb, r_ee, r_ea, r_pg;
    logic         r_e2;
    logic [W-1:0] r_rr, r_ss, r_u2;
    logic         r_vres;
    logic [1:0]   r_stat;
    logic         r_ov;
    // result held for the receiver
    logic [31:0]  r_out_r, r_out_s;
    logic         r_out_vres;
    logic [1:0]   r_out_stat;

    // shared unit
    logic         w_start;
    dsa_pkg::t_op w_op;
    logic [W-1:0] w_a, w_b, w_m, w_res, w_quo;
    logic         w_done;

    dsa_mod_unit #(.WORD_BITS(W)) u_unit (
        .i_clk, .i_rst_n, .i_start(w_start), .i_op(w_op), .i_a(w_a), .i_b(w_b),
        .i_m(w_m), .o_done(w_done), .o_res(w_res), .o_quo(w_quo)
    );

    logic w_acc_in, w_out_fire, w_load, w_deg, w_rng;
    assign w_acc_in   = i_valid && !o_stall;
    assign w_out_fire = r_ov && !i_stall;
    // load the output register once it is free or drains this cycle
    assign w_load     = (r_st == dsa_pkg::S_OUT) && (!r_ov || w_out_fire);
    assign o_stall    = (r_st != dsa_pkg::S_IDLE);
    assign w_deg      = (r_p < W'(2)) || (r_q < W'(2));
    assign w_rng      = (r_rin == '0) || (r_rin >= r_q) || (r_sin == '0) || (r_sin >= r_q);

    // value to invert: reduced k for sign, s for verify
    logic [W-1:0] w_r1_init;
    assign w_r1_init = (r_cmd == dsa_pkg::CMD_SIGN) ? r_k : r_sin;

    logic [W-1:0] w_tsub;
    // t0 - qt*t1 mod q, with product in w_res
    assign w_tsub = (r_t0 >= w_res) ? r_t0 - w_res : r_t0 + (r_q - w_res);

    // a phase is entered by a launch cycle; r_go marks launch done
    logic r_go, n_go;

    // unit launch (outputs block)
    always_comb begin
        w_start = 1'b0; w_op = dsa_pkg::OP_MOD;
        w_a = '0; w_b = '0; w_m = r_q;
        case (r_st)
            dsa_pkg::S_RED_H: begin w_a = r_h; end
            dsa_pkg::S_RED_K: begin w_a = r_k; end
            dsa_pkg::S_RED_X: begin w_a = r_x; end
            dsa_pkg::S_RED_G: begin w_a = r_g; w_m = r_p; end
            dsa_pkg::S_RED_Y: begin w_a = r_y; w_m = r_p; end
            dsa_pkg::S_INV_DIV: begin w_a = r_r0; w_m = r_r1; end
            dsa_pkg::S_INV_MUL: begin w_op = dsa_pkg::OP_MUL; w_a = r_t1; w_b = r_qt; end
            dsa_pkg::S_EXP_SQ:  begin w_op = dsa_pkg::OP_MUL; w_a = r_eb; w_b = r_eb; w_m = r_p; end
            dsa_pkg::S_EXP_MUL: begin w_op = dsa_pkg::OP_MUL; w_a = r_ea; w_b = r_eb; w_m = r_p; end
            dsa_pkg::S_SIGN_R:  begin w_a = r_ea; end
            dsa_pkg::S_SIGN_XR: begin w_op = dsa_pkg::OP_MUL; w_a = r_xm; w_b = r_rr; end
            dsa_pkg::S_SIGN_S:  begin w_op = dsa_pkg::OP_MUL; w_a = r_inv;
                w_b = (r_h >= r_q - r_ss) ? r_h - (r_q - r_ss) : r_h + r_ss; end
            dsa_pkg::S_VER_U1:  begin w_op = dsa_pkg::OP_MUL; w_a = r_h; w_b = r_inv; end
            dsa_pkg::S_VER_U2:  begin w_op = dsa_pkg::OP_MUL; w_a = r_rin; w_b = r_inv; end
            dsa_pkg::S_VER_V:   begin w_op = dsa_pkg::OP_MUL; w_a = r_pg; w_b = r_ea; w_m = r_p; end
            dsa_pkg::S_VER_VQ:  begin w_a = w_res; end
            default: ;
        endcase
        if (r_st == dsa_pkg::S_VER_VQ) w_a = r_ea;
        w_start = !r_go && (r_st inside {dsa_pkg::S_RED_H, dsa_pkg::S_RED_K,
            dsa_pkg::S_RED_X, dsa_pkg::S_RED_G, dsa_pkg::S_RED_Y, dsa_pkg::S_INV_DIV,
            dsa_pkg::S_INV_MUL, dsa_pkg::S_EXP_SQ, dsa_pkg::S_EXP_MUL,
            dsa_pkg::S_SIGN_R, dsa_pkg::S_SIGN_XR, dsa_pkg::S_SIGN_S,
            dsa_pkg::S_VER_U1, dsa_pkg::S_VER_U2, dsa_pkg::S_VER_V, dsa_pkg::S_VER_VQ});
    end

    // next state
    always_comb begin
        n_st = r_st;
        case (r_st)
            dsa_pkg::S_IDLE:  if (w_acc_in) n_st = dsa_pkg::S_CHECK;
            dsa_pkg::S_CHECK: begin
                if (w_deg || (r_cmd == dsa_pkg::CMD_VERIFY && w_rng)) n_st = dsa_pkg::S_OUT;
                else n_st = dsa_pkg::S_RED_H;
            end
            dsa_pkg::S_RED_H: if (w_done) n_st = dsa_pkg::S_RED_K;
            dsa_pkg::S_RED_K: if (w_done) n_st = dsa_pkg::S_RED_X;
            dsa_pkg::S_RED_X: if (w_done) n_st = dsa_pkg::S_RED_G;
            dsa_pkg::S_RED_G: if (w_done) n_st = dsa_pkg::S_RED_Y;
            dsa_pkg::S_RED_Y: if (w_done) n_st = (w_r1_init == '0) ? dsa_pkg::S_INV_END
                                                  : dsa_pkg::S_INV_DIV;
            dsa_pkg::S_INV_DIV: if (w_done) n_st = dsa_pkg::S_INV_MUL;
            dsa_pkg::S_INV_MUL: if (w_done) n_st = dsa_pkg::S_INV_STEP;
            dsa_pkg::S_INV_STEP: n_st = (r_r1 == '0) ? dsa_pkg::S_INV_END : dsa_pkg::S_INV_DIV;
            dsa_pkg::S_INV_END: begin
                if (r_cmd == dsa_pkg::CMD_VERIFY && r_r0 != W'(1)) n_st = dsa_pkg::S_OUT;
                else if (r_cmd == dsa_pkg::CMD_VERIFY) n_st = dsa_pkg::S_VER_U1;
                else n_st = dsa_pkg::S_EXP_END;
            end
            dsa_pkg::S_EXP_SQ:  if (w_done) n_st = dsa_pkg::S_EXP_END;
            dsa_pkg::S_EXP_MUL: if (w_done) n_st = dsa_pkg::S_EXP_SQ;
            dsa_pkg::S_EXP_END: begin
                if (r_ee != '0) n_st = r_ee[0] ? dsa_pkg::S_EXP_MUL : dsa_pkg::S_EXP_SQ;
                else if (r_cmd == dsa_pkg::CMD_SIGN) n_st = dsa_pkg::S_SIGN_R;
                else if (!r_e2) n_st = dsa_pkg::S_EXP_END;
                else n_st = dsa_pkg::S_VER_V;
            end
            dsa_pkg::S_SIGN_R:  if (w_done) n_st = dsa_pkg::S_SIGN_XR;
            dsa_pkg::S_SIGN_XR: if (w_done) n_st = dsa_pkg::S_SIGN_S;
            dsa_pkg::S_SIGN_S:  if (w_done) n_st = dsa_pkg::S_OUT;
            dsa_pkg::S_VER_U1:  if (w_done) n_st = dsa_pkg::S_VER_U2;
            dsa_pkg::S_VER_U2:  if (w_done) n_st = dsa_pkg::S_EXP_END;
            dsa_pkg::S_VER_V:   if (w_done) n_st = dsa_pkg::S_VER_VQ;
            dsa_pkg::S_VER_VQ:  if (w_done) n_st = dsa_pkg::S_OUT;
            // hold here until the output register can take the result
            dsa_pkg::S_OUT:     if (w_load) n_st = dsa_pkg::S_IDLE;
            default:            n_st = dsa_pkg::S_IDLE;
        endcase
        n_go = (n_st == r_st) && (r_go || w_start);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= dsa_pkg::S_IDLE;
            r_go <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r_st <= n_st;
            r_go <= n_go;
            if (w_load) r_ov <= 1'b1;
            else if (w_out_fire) r_ov <= 1'b0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_r    <= 32'(r_rr);
            r_out_s    <= 32'(r_ss);
            r_out_vres <= r_vres;
            r_out_stat <= r_stat;
        end
    end

    // datapath updates
    always_ff @(posedge i_clk) begin
        case (r_st)
            dsa_pkg::S_IDLE: if (w_acc_in) begin
                r_cmd <= i_cmd; r_h <= W'(i_hash_value); r_k <= W'(i_nonce);
                r_rin <= W'(i_sig_r); r_sin <= W'(i_sig_s);
                r_rr <= '0; r_ss <= '0; r_vres <= 1'b0; r_stat <= dsa_pkg::ST_OK;
                r_e2 <= 1'b0;
            end
            dsa_pkg::S_CHECK: if (w_deg || (r_cmd == dsa_pkg::CMD_VERIFY && w_rng))
                r_stat <= dsa_pkg::ST_RANGE;
            dsa_pkg::S_RED_H: if (w_done) r_h <= w_res;
            dsa_pkg::S_RED_K: if (w_done) r_k <= w_res;
            dsa_pkg::S_RED_X: if (w_done) r_xm <= w_res;
            dsa_pkg::S_RED_G: if (w_done) r_gm <= w_res;
            dsa_pkg::S_RED_Y: if (w_done) begin
                r_ym <= w_res;
                // start inverse of k (sign) or s (verify)
                r_r0 <= r_q; r_t0 <= '0; r_t1 <= W'(1);
                r_r1 <= w_r1_init;
            end
            dsa_pkg::S_INV_DIV: if (w_done) begin
                // quotient reaches q only on the first step with r1 equal to one
                r_qt <= (w_quo >= r_q) ? w_quo - r_q : w_quo;
                r_inv <= w_res;  // remainder
            end
            dsa_pkg::S_INV_MUL: if (w_done) begin
                r_r0 <= r_r1; r_r1 <= r_inv; r_t0 <= r_t1; r_t1 <= w_tsub;
            end
            dsa_pkg::S_INV_END: begin
                r_inv <= (r_r0 == W'(1)) ? r_t0 : '0;
                if (r_cmd == dsa_pkg::CMD_VERIFY && r_r0 != W'(1))
                    r_stat <= dsa_pkg::ST_RANGE;
                r_eb <= r_gm; r_ee <= r_k; r_ea <= (r_p == W'(1)) ? '0 : W'(1);
            end
            dsa_pkg::S_EXP_SQ: if (w_done) begin r_eb <= w_res; r_ee <= r_ee >> 1; end
            dsa_pkg::S_EXP_MUL: if (w_done) r_ea <= w_res;
            dsa_pkg::S_EXP_END: if (r_ee == '0 && r_cmd == dsa_pkg::CMD_VERIFY && !r_e2) begin
                // first exponentiation done: g^u1 saved, start y^u2
                r_pg <= r_ea; r_e2 <= 1'b1; r_eb <= r_ym; r_ee <= r_u2; r_ea <= W'(1);
            end
            dsa_pkg::S_SIGN_R:  if (w_done) r_rr <= w_res;
            dsa_pkg::S_SIGN_XR: if (w_done) r_ss <= w_res;
            dsa_pkg::S_SIGN_S:  if (w_done) begin
                r_ss <= w_res;
                if (r_rr == '0 || w_res == '0) r_stat <= dsa_pkg::ST_NONCE;
            end
            dsa_pkg::S_VER_U1: if (w_done) begin r_k <= w_res; end
            dsa_pkg::S_VER_U2: if (w_done) begin
                r_u2 <= w_res; r_eb <= r_gm; r_ee <= r_k; r_ea <= W'(1);
            end
            dsa_pkg::S_VER_V:  if (w_done) r_ea <= w_res;
            dsa_pkg::S_VER_VQ: if (w_done) r_vres <= (w_res == r_rin);
            default: ;
        endcase
    end

    assign o_valid     = r_ov;
    assign o_out_r     = r_out_r;
    assign o_out_s     = r_out_s;
    assign o_valid_res = r_out_vres;
    assign o_status    = r_out_stat;
endmodule

FILE: rtl/dsa_checker.sv
module dsa_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic       o_valid_res,
    input logic [1:0] o_status
);
    // accepted request blocks the input next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall) else $error("not busy after request");
    // a stalled result keeps its accept flag and status
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> ($stable(o_valid_res) && $stable(o_status)))
        else $error("result changed while stalled");
    // accepted verify always reports OK status with accept, never a nonce or range failure
    a_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_valid_res) |-> (o_status == dsa_pkg::ST_OK)) else $error("bad status");
    // result stays while stalled
    a_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid) else $error("result dropped");
endmodule

bind dsa_sign_verify dsa_checker u_chk (
    .i_clk, .i_rst_n, .i_valid, .o_stall, .o_valid, .i_stall, .o_valid_res, .o_status
);

FILE: tb/sv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  N_RANDOM    = 120;
    // Allow a wide margin over the time the requests take on a 32-bit group.
    localparam longint CYCLE_LIMIT = 64'd8_000_000;
    localparam int  DRAIN_CYCLES = 200;
    localparam int  HOLDOFF_CYCLES = 30000;

    typedef struct packed {
        logic [31:0] out_r;
        logic [31:0] out_s;
        logic        valid_res;
        logic [1:0]  status;
    } t_dsa_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_cmd = dsa_pkg::CMD_SIGN;
    logic [31:0] i_hash_value = '0;
    logic [31:0] i_nonce = '0;
    logic [31:0] i_sig_r = '0;
    logic [31:0] i_sig_s = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_out_r;
    logic [31:0] o_out_s;
    logic        o_valid_res;
    logic [1:0]  o_status;

    dsa_sign_verify uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_stall(o_stall), .i_cmd(i_cmd),
        .i_hash_value(i_hash_value), .i_nonce(i_nonce),
        .i_sig_r(i_sig_r), .i_sig_s(i_sig_s),
        .o_valid(o_valid), .i_stall(i_stall), .o_out_r(o_out_r), .o_out_s(o_out_s),
        .o_valid_res(o_valid_res), .o_status(o_status)
    );

    always #6 i_clk = ~i_clk;

    // Local copy of the group and key registers.
    logic [31:0] grp_p, grp_q, grp_g, key_x, key_y;

    t_dsa_result pending_results[$];
    int     mismatches = 0;
    int     results_seen = 0;
    int     signs_sent = 0, verifies_sent = 0, accepts_seen = 0;
    longint cycle_count = 0;
    bit     idle_enable = 1'b0;     // random gaps on both sides
    bit     holdoff_go = 1'b0;      // start the receiver hold-off
    bit     holdoff_done = 1'b0;
    int     holdoff_count = 0;      // receiver hold-off length, counted below

    // ---------------- modular arithmetic for prediction ----------------
    function automatic logic [63:0] mulmod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
        return ((a % m) * (b % m)) % m;
    endfunction

    function automatic logic [63:0] powmod(logic [63:0] b, logic [63:0] e, logic [63:0] m);
        logic [63:0] acc;
        acc = 64'd1 % m;
        b = b % m;
        while (e != 0) begin
            if (e[0]) acc = mulmod(acc, b, m);
            b = mulmod(b, b, m);
            e = e >> 1;
        end
        return acc;
    endfunction

    // Extended Euclid; zero when no inverse exists.
    function automatic logic [63:0] invmod(logic [63:0] a, logic [63:0] m);
        logic [63:0] r0, r1, t0, t1, qt, nr, nt;
        r0 = m; r1 = a % m; t0 = 0; t1 = 1;
        while (r1 != 0) begin
            qt = r0 / r1;
            nr = r0 - qt * r1;
            nt = (t0 + m - mulmod(qt, t1, m)) % m;
            r0 = r1; r1 = nr; t0 = t1; t1 = nt;
        end
        return (r0 == 1) ? t0 : 64'd0;
    endfunction

    function automatic t_dsa_result predict_signature(logic cmd, logic [31:0] h,
            logic [31:0] k, logic [31:0] r, logic [31:0] s);
        t_dsa_result res;
        logic [63:0] p, q, kr, kinv, rr, ss, w, u1, u2, v;
        res = '0;
        p = grp_p; q = grp_q;
        if (p < 2 || q < 2) begin
            res.status = dsa_pkg::ST_RANGE;
        end else if (cmd == dsa_pkg::CMD_SIGN) begin
            kr   = k % q;
            kinv = invmod(kr, q);
            rr   = powmod(grp_g, kr, p) % q;
            ss   = mulmod(kinv, ((h % q) + mulmod(key_x, rr, q)) % q, q);
            res.out_r = rr[31:0];
            res.out_s = ss[31:0];
            res.status = (rr == 0 || ss == 0) ? dsa_pkg::ST_NONCE : dsa_pkg::ST_OK;
        end else if (r == 0 || r >= q || s == 0 || s >= q) begin
            res.status = dsa_pkg::ST_RANGE;
        end else begin
            w = invmod(s, q);
            if (w == 0) begin
                res.status = dsa_pkg::ST_RANGE;
            end else begin
                u1 = mulmod(h, w, q);
                u2 = mulmod(r, w, q);
                v  = mulmod(powmod(grp_g, u1, p), powmod(key_y, u2, p), p) % q;
                res.valid_res = (v == r);
            end
        end
        return res;
    endfunction

    // ---------------- drivers ----------------
    // Write enable drops when the next request is offered.
    task automatic write_reg(int idx, logic [31:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx[2:0];
        i_cfg_data  <= value;
        @(posedge i_clk);
        case (idx)
            dsa_pkg::REG_P: grp_p = value;
            dsa_pkg::REG_Q: grp_q = value;
            dsa_pkg::REG_G: grp_g = value;
            dsa_pkg::REG_X: key_x = value;
            dsa_pkg::REG_Y: key_y = value;
            default: ;
        endcase
    endtask

    task automatic set_group(logic [31:0] p, logic [31:0] q, logic [31:0] g,
            logic [31:0] x, logic [31:0] y);
        write_reg(dsa_pkg::REG_P, p);
        write_reg(dsa_pkg::REG_Q, q);
        write_reg(dsa_pkg::REG_G, g);
        write_reg(dsa_pkg::REG_X, x);
        write_reg(dsa_pkg::REG_Y, y);
    endtask

    // Offer one request and hold it until the block takes it.
    task automatic send_request(logic cmd, logic [31:0] h, logic [31:0] k,
            logic [31:0] r, logic [31:0] s);
        i_cfg_we <= 1'b0;
        while (idle_enable && $urandom_range(99) < 17) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_cmd        <= cmd;
        i_hash_value <= h;
        i_nonce      <= k;
        i_sig_r      <= r;
        i_sig_s      <= s;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_results.push_back(predict_signature(cmd, h, k, r, s));
        if (cmd == dsa_pkg::CMD_SIGN) signs_sent++; else verifies_sent++;
    endtask

    // Sign with the current key, then verify the produced pair and, one time in four, a tampered hash.
    task automatic sign_and_verify(logic [31:0] h, logic [31:0] k);
        t_dsa_result sig;
        sig = predict_signature(dsa_pkg::CMD_SIGN, h, k, 0, 0);
        send_request(dsa_pkg::CMD_SIGN, h, k, $urandom, $urandom);
        send_request(dsa_pkg::CMD_VERIFY, h, $urandom, sig.out_r, sig.out_s);
        if ($urandom_range(3) == 0)
            send_request(dsa_pkg::CMD_VERIFY, h ^ (32'd1 << $urandom_range(31)), $urandom,
                         sig.out_r, sig.out_s);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // ---------------- result checker ----------------
    always @(posedge i_clk) begin
        t_dsa_result got, want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_out_r, o_out_s, o_valid_res, o_status};
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result r=%0d s=%0d", o_out_r, o_out_s);
            end else begin
                want = pending_results.pop_front();
                if (got.valid_res && got.status == dsa_pkg::ST_OK && want == got) accepts_seen++;
                if (got != want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp r=%0d s=%0d v=%0b st=%0d got r=%0d s=%0d v=%0b st=%0d",
                                 want.out_r, want.out_s, want.valid_res, want.status,
                                 got.out_r, got.out_s, got.valid_res, got.status);
                end
            end
        end
    end

    // Receiver stall: random gaps, or one long hold-off counted here.
    always @(posedge i_clk) begin
        if (holdoff_go && !holdoff_done) begin
            i_stall <= 1'b1;
            holdoff_count <= holdoff_count + 1;
            if (holdoff_count == HOLDOFF_CYCLES - 1) holdoff_done <= 1'b1;
        end else begin
            i_stall <= idle_enable && ($urandom_range(99) < 17);
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout with %0d results outstanding", pending_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ---------------- tests ----------------
    task automatic test_reset_group();
        // Reset values: p=23 q=11 g=4 x=1 y=4.
        send_request(dsa_pkg::CMD_SIGN, 32'd0, 32'd1, 0, 0);
        send_request(dsa_pkg::CMD_SIGN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0);
        send_request(dsa_pkg::CMD_SIGN, 32'd5, 32'd11, 0, 0);         // nonce multiple of q
        send_request(dsa_pkg::CMD_SIGN, 32'd10, 32'd3, 0, 0);
        send_request(dsa_pkg::CMD_VERIFY, 32'd5, 0, 32'd0, 32'd3);    // zero r
        send_request(dsa_pkg::CMD_VERIFY, 32'd5, 0, 32'd3, 32'd11);   // s not below q
        send_request(dsa_pkg::CMD_VERIFY, 32'd5, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        sign_and_verify(32'd7, 32'd4);
        send_request(dsa_pkg::CMD_VERIFY, 32'd7, 0, 32'd2, 32'd3);    // in range, likely rejected
        wait_drained();
    endtask

    task automatic test_degenerate_group();
        set_group(32'd1, 32'd11, 32'd4, 32'd1, 32'd4);
        send_request(dsa_pkg::CMD_SIGN, 32'd3, 32'd2, 0, 0);
        wait_drained();
        write_reg(dsa_pkg::REG_P, 32'd23);
        write_reg(dsa_pkg::REG_Q, 32'd0);
        send_request(dsa_pkg::CMD_VERIFY, 32'd3, 0, 32'd1, 32'd1);
        wait_drained();
        write_reg(dsa_pkg::REG_Q, 32'd6);                           // composite q
        send_request(dsa_pkg::CMD_VERIFY, 32'd3, 0, 32'd1, 32'd2);  // s has no inverse
        send_request(dsa_pkg::CMD_SIGN, 32'd3, 32'd4, 0, 0);        // nonce has no inverse
        wait_drained();
    endtask

    task automatic test_wide_group();
        // p = 2^32-5 is prime; q = 2 divides p-1; g = p-1 has order 2.
        set_group(32'hFFFF_FFFB, 32'd2, 32'hFFFF_FFFA, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(dsa_pkg::CMD_SIGN, 32'hFFFF_FFFF, 32'd1, 0, 0);
        send_request(dsa_pkg::CMD_VERIFY, 32'hFFFF_FFFF, 0, 32'd1, 32'd1);
        wait_drained();
        // q = 2^32-1 and large operands exercise every bit of every field.
        set_group(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(dsa_pkg::CMD_SIGN, 32'hFFFF_FFFE, 32'hFFFF_FFFE, 0, 0);
        send_request(dsa_pkg::CMD_VERIFY, 32'hFFFF_FFFE, 0, 32'hFFFF_FFFE, 32'h8000_0000);
        wait_drained();
    endtask

    // Random traffic on two realistic groups: mostly sign-then-verify pairs.
    task automatic test_random_traffic();
        logic [31:0] groups [3][3] = '{'{32'd23, 32'd11, 32'd4},
                                      '{32'd607, 32'd101, 32'd64},
                                      '{32'd2147483647, 32'd1103, 32'd0}};
        int sent_mark, gi;
        logic [31:0] x;
        idle_enable = 1'b1;
        for (int phase = 0; phase < 4; phase++) begin
            gi = phase % 2;
            x  = $urandom_range(groups[gi][1] - 1, 1);
            set_group(groups[gi][0], groups[gi][1], groups[gi][2], x,
                      32'(powmod(groups[gi][2], x, groups[gi][0])));
            if (phase == 2) idle_enable = 1'b0;   // stretch with no gaps
            if (phase == 3) begin
                idle_enable = 1'b1;
                holdoff_go = 1'b1;                 // block fills and stalls input
            end
            sent_mark = signs_sent + verifies_sent;
            while (signs_sent + verifies_sent - sent_mark < N_RANDOM / 4) begin
                case ($urandom_range(9))
                    0: send_request(dsa_pkg::CMD_SIGN, $urandom, $urandom, $urandom, $urandom);
                    1: send_request(dsa_pkg::CMD_VERIFY, $urandom, $urandom,
                                    $urandom_range(groups[gi][1]), $urandom_range(groups[gi][1]));
                    2: send_request(dsa_pkg::CMD_VERIFY, $urandom, $urandom, $urandom, $urandom);
                    default: sign_and_verify($urandom, $urandom_range(groups[gi][1] - 1, 1));
                endcase
            end
            wait_drained();
        end
        idle_enable = 1'b0;
    endtask

    initial begin
        grp_p = 32'd23; grp_q = 32'd11; grp_g = 32'd4; key_x = 32'd1; key_y = 32'd4;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_group();
        test_degenerate_group();
        test_wide_group();
        test_random_traffic();

        if (pending_results.size() != 0) mismatches += pending_results.size();
        $display("covered %0d signs and %0d verifies, %0d results, %0d accepted signatures",
                 signs_sent, verifies_sent, results_seen, accepts_seen);
        $display("groups: reset, degenerate, composite q, 32-bit extremes, random");
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

FILE: filelist.f
rtl/dsa_pkg.sv
rtl/dsa_mod_unit.sv
rtl/dsa_sign_verify.sv
rtl/dsa_checker.sv
tb/sv/tb_top.sv
